// ===== design/vgm_command_stream_parser_defines.svh =====
// assertion macros for the command stream parser checker
// no dependencies; included by the checker file
`ifndef VGM_COMMAND_STREAM_PARSER_DEFINES_SVH
`define VGM_COMMAND_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VCSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcsp assertion failed");

// next-cycle implication, disabled while in reset
`define VCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcsp assertion failed");

`endif

// ===== design/vcsp_pkg.sv =====
// types and constants for the command stream parser
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package vcsp_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_STEREO  = 3'd1,
    PH_TONE    = 3'd2,
    PH_FM_ADDR = 3'd3,
    PH_FM_DATA = 3'd4,
    PH_WAIT_LO = 3'd5,
    PH_WAIT_HI = 3'd6,
    PH_SKIP    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    EV_STEREO  = 3'd0,
    EV_TONE    = 3'd1,
    EV_FM      = 3'd2,
    EV_WAIT    = 3'd3,
    EV_END     = 3'd4,
    EV_UNKNOWN = 3'd5
  } event_kind_e;

  localparam logic [7:0] OP_STEREO       = 8'h4f;
  localparam logic [7:0] OP_TONE         = 8'h50;
  localparam logic [7:0] OP_FM           = 8'h51;
  localparam logic [7:0] OP_WAIT_LONG    = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC    = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL     = 8'h63;
  localparam logic [7:0] OP_END          = 8'h66;
  localparam logic [7:0] OP_WAIT_SHORT_LO = 8'h70;
  localparam logic [7:0] OP_WAIT_SHORT_HI = 8'h7f;
  localparam logic [7:0] OP_SKIP_TWO     = 8'ha0;
  localparam logic [7:0] OP_SKIP_THREE   = 8'hd2;

  localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;
  localparam logic [3:0]  NIBBLE_MASK       = 4'hf;

  localparam logic [1:0] SKIP_TWO   = 2'd2;
  localparam logic [1:0] SKIP_THREE = 2'd3;

  localparam int unsigned PADDR_W        = 3;
  localparam logic        REG_LOOP_OFFSET = 1'b0;
  localparam logic [31:0] LOOP_OFFSET_RESET = 32'd64;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  reg_address;
    logic [15:0] payload;
    logic [31:0] jump_target;
  } event_t;

  typedef struct packed {
    logic   emit;
    event_t evt;
  } decode_t;

endpackage

// ===== design/vcsp_byte_if.sv =====
// stream byte channel with valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface vcsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== design/vcsp_event_if.sv =====
// decoded event channel with valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface vcsp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  reg_address;
  logic [15:0] payload;
  logic [31:0] jump_target;

  modport source (output valid, output event_kind, output reg_address, output payload,
                  output jump_target, input ready);
  modport sink (input valid, input event_kind, input reg_address, input payload,
                input jump_target, output ready);
endinterface

// ===== design/vcsp_decoder.sv =====
// opcode and operand decoder with parse state registers
// depends on vcsp_pkg
`timescale 1ns / 1ps

module vcsp_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [31:0]       loop_offset_i,
  output vcsp_pkg::decode_t dec_o
);
  import vcsp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [1:0] skip_q, skip_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] wait_lo_q, wait_lo_d;

  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    addr_d    = addr_q;
    wait_lo_d = wait_lo_q;
    dec_o     = '0;
    case (phase_q)
      PH_STEREO: begin
        phase_d             = PH_OPCODE;
        dec_o.emit          = 1'b1;
        dec_o.evt.kind      = EV_STEREO;
        dec_o.evt.payload   = {8'h00, byte_i};
      end
      PH_TONE: begin
        phase_d             = PH_OPCODE;
        dec_o.emit          = 1'b1;
        dec_o.evt.kind      = EV_TONE;
        dec_o.evt.payload   = {8'h00, byte_i};
      end
      PH_FM_ADDR: begin
        addr_d  = byte_i;
        phase_d = PH_FM_DATA;
      end
      PH_FM_DATA: begin
        phase_d               = PH_OPCODE;
        dec_o.emit            = 1'b1;
        dec_o.evt.kind        = EV_FM;
        dec_o.evt.reg_address = addr_q;
        dec_o.evt.payload     = {8'h00, byte_i};
      end
      PH_WAIT_LO: begin
        wait_lo_d = byte_i;
        phase_d   = PH_WAIT_HI;
      end
      PH_WAIT_HI: begin
        phase_d           = PH_OPCODE;
        dec_o.emit        = 1'b1;
        dec_o.evt.kind    = EV_WAIT;
        dec_o.evt.payload = {byte_i, wait_lo_q};
      end
      PH_SKIP: begin
        if (skip_q > 2'd1) begin
          skip_d = skip_q - 2'd1;
        end else begin
          skip_d  = 2'd0;
          phase_d = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        if (byte_i inside {[OP_WAIT_SHORT_LO:OP_WAIT_SHORT_HI]}) begin
          dec_o.emit        = 1'b1;
          dec_o.evt.kind    = EV_WAIT;
          dec_o.evt.payload = {12'h000, byte_i[3:0] & NIBBLE_MASK} + 16'd1;
        end else begin
          case (byte_i)
            OP_STEREO:    phase_d = PH_STEREO;
            OP_TONE:      phase_d = PH_TONE;
            OP_FM:        phase_d = PH_FM_ADDR;
            OP_WAIT_LONG: phase_d = PH_WAIT_LO;
            OP_WAIT_NTSC: begin
              dec_o.emit        = 1'b1;
              dec_o.evt.kind    = EV_WAIT;
              dec_o.evt.payload = WAIT_NTSC_SAMPLES;
            end
            OP_WAIT_PAL: begin
              dec_o.emit        = 1'b1;
              dec_o.evt.kind    = EV_WAIT;
              dec_o.evt.payload = WAIT_PAL_SAMPLES;
            end
            OP_END: begin
              dec_o.emit            = 1'b1;
              dec_o.evt.kind        = EV_END;
              dec_o.evt.jump_target = loop_offset_i;
            end
            OP_SKIP_TWO: begin
              skip_d  = SKIP_TWO;
              phase_d = PH_SKIP;
            end
            OP_SKIP_THREE: begin
              skip_d  = SKIP_THREE;
              phase_d = PH_SKIP;
            end
            default: begin
              dec_o.emit        = 1'b1;
              dec_o.evt.kind    = EV_UNKNOWN;
              dec_o.evt.payload = {8'h00, byte_i};
            end
          endcase
        end
      end
      default: phase_d = PH_OPCODE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_OPCODE;
      skip_q    <= 2'd0;
      addr_q    <= 8'h00;
      wait_lo_q <= 8'h00;
    end else if (step_i) begin
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      addr_q    <= addr_d;
      wait_lo_q <= wait_lo_d;
    end
  end

endmodule

// ===== design/vcsp_out_buf.sv =====
// two-entry result buffer that decouples decode from the event sink
// depends on vcsp_pkg
`timescale 1ns / 1ps

module vcsp_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vcsp_pkg::event_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output vcsp_pkg::event_t data_o
);
  import vcsp_pkg::*;

  event_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/vgm_command_stream_parser.sv =====
// command stream parser top level: input register, decoder, result buffer, apb register
// depends on vcsp_pkg, vcsp_byte_if, vcsp_event_if, vcsp_decoder, vcsp_out_buf
//
//   channel    dir  handshake          payload
//   byte_in    in   valid/ready        stream_byte[7:0]
//   event_out  out  valid/ready        event_kind, reg_address, payload, jump_target
//   apb        in   psel/penable/pwrite  loop_offset at address 0
//
// one byte per cycle unless a full buffer stalls an event byte; an event is offered once
// its last byte passes byte_q into the buffer; decoder state steps as byte_q moves on
// rst_ni clears parse state, buffer pointers and sets loop_offset to 64
// a stalled sink holds up to two events before byte_in.ready drops
// bytes that produce no event keep moving while the buffer is full
`timescale 1ns / 1ps

module vgm_command_stream_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  vcsp_byte_if.sink                          byte_in,
  vcsp_event_if.source                       event_out,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vcsp_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import vcsp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic [31:0] loop_offset_q;
  logic        full;
  logic        advance;
  logic        cfg_write;
  decode_t     dec;
  event_t      head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_LOOP_OFFSET) ? loop_offset_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_offset_q <= LOOP_OFFSET_RESET;
    end else if (cfg_write && (paddr[2] == REG_LOOP_OFFSET)) begin
      loop_offset_q <= pwdata;
    end
  end

  assign advance      = in_valid_q && (!dec.emit || !full);
  assign byte_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid_q <= byte_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in.ready && byte_in.valid) begin
      byte_q <= byte_in.stream_byte;
    end
  end

  vcsp_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (byte_q),
    .loop_offset_i (loop_offset_q),
    .dec_o         (dec)
  );

  vcsp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance && dec.emit),
    .data_i  (dec.evt),
    .full_o  (full),
    .valid_o (event_out.valid),
    .ready_i (event_out.ready),
    .data_o  (head)
  );

  assign event_out.event_kind  = head.kind;
  assign event_out.reg_address = head.reg_address;
  assign event_out.payload     = head.payload;
  assign event_out.jump_target = head.jump_target;

endmodule

// ===== design/vcsp_checker.sv =====
// port-level checks on the event channel of the command stream parser
// depends on vcsp_pkg and vgm_command_stream_parser_defines.svh; bound to the top level
`timescale 1ns / 1ps
`include "vgm_command_stream_parser_defines.svh"

module vcsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        ev_valid_i,
  input logic        ev_ready_i,
  input logic [2:0]  event_kind_i,
  input logic [7:0]  reg_address_i,
  input logic [15:0] payload_i,
  input logic [31:0] jump_target_i
);
  import vcsp_pkg::*;

  // only defined event codes leave the block
  `VCSP_ASSERT_IMPL(a_kind_legal, clk_i, rst_ni, ev_valid_i, event_kind_i <= EV_UNKNOWN)
  // only fm writes carry a register address
  `VCSP_ASSERT_IMPL(a_addr_fm_only, clk_i, rst_ni, ev_valid_i && (event_kind_i != EV_FM), reg_address_i == 8'h00)
  // only the end event carries a jump target, and no payload
  `VCSP_ASSERT_IMPL(a_target_end_only, clk_i, rst_ni, ev_valid_i && (event_kind_i != EV_END), jump_target_i == 32'h0)
  `VCSP_ASSERT_IMPL(a_end_no_payload, clk_i, rst_ni, ev_valid_i && (event_kind_i == EV_END), payload_i == 16'h0)
  // a pending transfer keeps its kind
  `VCSP_ASSERT_NEXT(a_kind_hold, clk_i, rst_ni, ev_valid_i && !ev_ready_i, $stable(event_kind_i))

endmodule

bind vgm_command_stream_parser vcsp_checker u_vcsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .ev_valid_i    (event_out.valid),
  .ev_ready_i    (event_out.ready),
  .event_kind_i  (event_out.event_kind),
  .reg_address_i (event_out.reg_address),
  .payload_i     (event_out.payload),
  .jump_target_i (event_out.jump_target)
);
